### sv/ss_pkg.sv
package ss_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int CNT_W       = 32;
	localparam int CQ_DEPTH    = 4;
	localparam int CQ_AW       = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH    = 2;
	localparam int RQ_AW       = $clog2(RQ_DEPTH);

	localparam logic [7:0] ASCII_A     = 8'h41;
	localparam logic [7:0] ASCII_Z     = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] pos;
		logic             ovf;
	} res_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic ci);
		logic [7:0] r;
		r = c;
		if (ci && c >= ASCII_A && c <= ASCII_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

### sv/ss_front.sv
module ss_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    kind,
	input  logic [7:0]    byte_value,
	output logic          cmd_valid,
	output ss_pkg::cmd_t  cmd,
	input  logic          cmd_pop
);

	ss_pkg::cmd_t            cq_q [ss_pkg::CQ_DEPTH];
	logic [ss_pkg::CQ_AW-1:0] wr_ptr_q;
	logic [ss_pkg::CQ_AW-1:0] rd_ptr_q;
	logic [ss_pkg::CQ_AW:0]   cnt_q;
	ss_pkg::cmd_t            dec;
	logic                    wr_en;

	always_comb begin
		dec.data = 8'd0;
		unique case (kind)
			ss_pkg::OP_CLEAR: dec.op = ss_pkg::OP_CLEAR;
			ss_pkg::OP_APPEND: begin
				dec.op   = ss_pkg::OP_APPEND;
				dec.data = byte_value;
			end
			ss_pkg::OP_TEXT: begin
				dec.op   = ss_pkg::OP_TEXT;
				dec.data = byte_value;
			end
			default: dec.op = ss_pkg::OP_END;
		endcase
	end

	assign full      = (cnt_q == (ss_pkg::CQ_AW+1)'(ss_pkg::CQ_DEPTH));
	assign wr_en     = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cq_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + ss_pkg::CQ_AW'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + ss_pkg::CQ_AW'(1);
			end
			if (wr_en && !cmd_pop) begin
				cnt_q <= cnt_q + (ss_pkg::CQ_AW+1)'(1);
			end else if (!wr_en && cmd_pop) begin
				cnt_q <= cnt_q - (ss_pkg::CQ_AW+1)'(1);
			end
		end
	end

endmodule

### sv/ss_back.sv
module ss_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_data,
	input  logic          cmd_valid,
	input  ss_pkg::cmd_t  cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output ss_pkg::res_t  res
);

	// pattern kept newest-first so byte j lines up with window byte j
	logic [7:0]               pat_q [ss_pkg::MAX_PATTERN];
	logic [7:0]               win_q [ss_pkg::MAX_PATTERN];
	logic [7:0]               win_nx [ss_pkg::MAX_PATTERN];
	logic [ss_pkg::LEN_W-1:0] len_q;
	logic                     ovf_q;
	logic                     ci_q;
	logic [ss_pkg::CNT_W-1:0] cnt_q;
	logic [ss_pkg::CNT_W-1:0] cnt_nx;
	logic                     seen_q;
	logic [ss_pkg::CNT_W-1:0] start_q;
	logic [ss_pkg::MAX_PATTERN-1:0] lane_ok;
	logic                     hit;
	logic                     room;

	always_comb begin
		win_nx[0] = cmd.data;
		for (int j = 1; j < ss_pkg::MAX_PATTERN; j++) begin
			win_nx[j] = win_q[j-1];
		end
		cnt_nx = (cnt_q == '1) ? cnt_q : cnt_q + ss_pkg::CNT_W'(1);
		for (int j = 0; j < ss_pkg::MAX_PATTERN; j++) begin
			lane_ok[j] = (ss_pkg::LEN_W'(j) >= len_q) ||
				(ss_pkg::fold(pat_q[j], ci_q) == ss_pkg::fold(win_nx[j], ci_q));
		end
		hit = (len_q != '0) && (cnt_nx >= ss_pkg::CNT_W'(len_q)) && (&lane_ok);
	end

	assign room     = (len_q < ss_pkg::LEN_W'(ss_pkg::MAX_PATTERN));
	assign res_push = cmd_valid && (cmd.op == ss_pkg::OP_END) && !res_full;
	assign cmd_pop  = cmd_valid && ((cmd.op != ss_pkg::OP_END) || !res_full);

	assign res.found = (len_q == '0) || seen_q;
	assign res.pos   = (len_q == '0) ? '0 : start_q;
	assign res.ovf   = ovf_q;

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == ss_pkg::OP_APPEND && room) begin
			pat_q[0] <= cmd.data;
			for (int j = 1; j < ss_pkg::MAX_PATTERN; j++) begin
				pat_q[j] <= pat_q[j-1];
			end
		end
		if (cmd_pop && cmd.op == ss_pkg::OP_TEXT) begin
			for (int j = 0; j < ss_pkg::MAX_PATTERN; j++) begin
				win_q[j] <= win_nx[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			ci_q    <= 1'b0;
			cnt_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
		end else begin
			if (cfg_we) begin
				ci_q <= cfg_data;
			end
			if (cmd_pop) begin
				unique case (cmd.op)
					ss_pkg::OP_CLEAR: begin
						len_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= '0;
						seen_q  <= 1'b0;
						start_q <= '0;
					end
					ss_pkg::OP_APPEND: begin
						if (room) begin
							len_q <= len_q + ss_pkg::LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					ss_pkg::OP_TEXT: begin
						cnt_q <= cnt_nx;
						if (!seen_q && hit) begin
							seen_q  <= 1'b1;
							start_q <= cnt_nx - ss_pkg::CNT_W'(len_q);
						end
					end
					default: begin
						cnt_q   <= '0;
						seen_q  <= 1'b0;
						start_q <= '0;
					end
				endcase
			end
		end
	end

endmodule

### sv/ss_res_queue.sv
module ss_res_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      res_push,
	input  ss_pkg::res_t              res,
	output logic                      res_full,
	input  logic                      pop,
	output logic                      empty,
	output logic                      found,
	output logic [ss_pkg::CNT_W-1:0]  match_position,
	output logic                      pattern_overflow
);

	ss_pkg::res_t             rq_q [ss_pkg::RQ_DEPTH];
	logic [ss_pkg::RQ_AW-1:0] wr_ptr_q;
	logic [ss_pkg::RQ_AW-1:0] rd_ptr_q;
	logic [ss_pkg::RQ_AW:0]   cnt_q;
	ss_pkg::res_t             head;
	logic                     rd_en;

	assign res_full         = (cnt_q == (ss_pkg::RQ_AW+1)'(ss_pkg::RQ_DEPTH));
	assign empty            = (cnt_q == '0);
	assign rd_en            = pop && !empty;
	assign head             = rq_q[rd_ptr_q];
	assign found            = head.found;
	assign match_position   = head.pos;
	assign pattern_overflow = head.ovf;

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + ss_pkg::RQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + ss_pkg::RQ_AW'(1);
			end
			if (res_push && !rd_en) begin
				cnt_q <= cnt_q + (ss_pkg::RQ_AW+1)'(1);
			end else if (!res_push && rd_en) begin
				cnt_q <= cnt_q - (ss_pkg::RQ_AW+1)'(1);
			end
		end
	end

endmodule

### sv/substring_search_top.sv
// Streaming first-match search: clear and append beats load a pattern of up to 16 bytes, text
// beats stream bytes through a 16-byte window compared in parallel against the whole pattern,
// and an end-of-text beat yields one result (found, zero-based start of the first match,
// pattern overflow) and readies the block for the next text while keeping the pattern. The
// block takes one beat per cycle while not full; a beat passes a 4-entry command queue and then
// the execute stage, whose window compare and position update keep that rate. A result enters a
// 2-entry queue and shows in the cycle after its end-of-text beat is taken; input stalls only
// once an end-of-text beat meets a full result queue. cfg_data sets case-insensitive compare.
module substring_search_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [7:0]  byte_value,
	input  logic        pop,
	output logic        empty,
	output logic        found,
	output logic [31:0] match_position,
	output logic        pattern_overflow,
	input  logic        cfg_we,
	input  logic        cfg_data
);

	logic          cmd_valid;
	ss_pkg::cmd_t  cmd;
	logic          cmd_pop;
	logic          res_full;
	logic          res_push;
	ss_pkg::res_t  res;

	ss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.byte_value (byte_value),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	ss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	ss_res_queue u_res_queue (
		.clk              (clk),
		.arst_n           (arst_n),
		.res_push         (res_push),
		.res              (res),
		.res_full         (res_full),
		.pop              (pop),
		.empty            (empty),
		.found            (found),
		.match_position   (match_position),
		.pattern_overflow (pattern_overflow)
	);

	a_beat_reaches_back: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> cmd_valid)
		else $error("accepted beat not queued");

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_end_held: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd.op == ss_pkg::OP_END && res_full) |-> (!cmd_pop && !res_push))
		else $error("end of text consumed while result queue full");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !empty)
		else $error("result lost");

endmodule

### tb/substring_search_top_tb.sv
module substring_search_top_tb;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RANDOM_BEATS   = 900;
	localparam int HOLD_CYCLES    = 80;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        push       = 1'b0;
	logic        full;
	logic [1:0]  kind       = ss_pkg::OP_CLEAR;
	logic [7:0]  byte_value = 8'h00;
	logic        pop        = 1'b0;
	logic        empty;
	logic        found;
	logic [31:0] match_position;
	logic        pattern_overflow;
	logic        cfg_we     = 1'b0;
	logic        cfg_data   = 1'b0;

	substring_search_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.kind             (kind),
		.byte_value       (byte_value),
		.pop              (pop),
		.empty            (empty),
		.found            (found),
		.match_position   (match_position),
		.pattern_overflow (pattern_overflow),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data)
	);

	always #4 clk = ~clk;

	// search state as the block should hold it
	logic [7:0]  pat_bytes [ss_pkg::MAX_PATTERN];
	int          pat_len   = 0;
	bit          pat_ovf   = 1'b0;
	logic [7:0]  txt_win   [ss_pkg::MAX_PATTERN];
	logic [31:0] txt_count = '0;
	bit          hit_seen  = 1'b0;
	logic [31:0] hit_start = '0;
	bit          case_mode = 1'b0;

	ss_pkg::res_t expected_results[$];

	int errors            = 0;
	int beats_sent        = 0;
	int results_checked   = 0;
	int cfg_writes        = 0;
	int full_stall_cycles = 0;
	int quiet_cycles      = 0;
	bit tx_idle_on        = 1'b1;
	bit rx_idle_on        = 1'b1;
	int rx_hold_req       = 0;

	function automatic logic [7:0] to_lower_ci(input logic [7:0] c);
		if (case_mode && c >= ss_pkg::ASCII_A && c <= ss_pkg::ASCII_Z) begin
			return c + ss_pkg::CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic logic [7:0] case_flip(input logic [7:0] c);
		bit letter;
		letter = (c >= ss_pkg::ASCII_A && c <= ss_pkg::ASCII_Z) ||
			(c >= ss_pkg::ASCII_A + ss_pkg::CASE_OFFSET &&
			 c <= ss_pkg::ASCII_Z + ss_pkg::CASE_OFFSET);
		if (letter && $urandom_range(0, 1)) begin
			return c ^ ss_pkg::CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: c = 8'($urandom_range(0, 255));
			1: c = 8'($urandom_range(ss_pkg::ASCII_A - 1, ss_pkg::ASCII_Z + 1));
			default: c = $urandom_range(0, 1) ? 8'h61 : 8'h62;
		endcase
		return case_flip(c);
	endfunction

	task automatic restart_text();
		foreach (txt_win[i]) txt_win[i] = 8'h00;
		txt_count = '0;
		hit_seen  = 1'b0;
		hit_start = '0;
	endtask

	task automatic predict_search(input ss_pkg::op_t k, input logic [7:0] b);
		ss_pkg::res_t r;
		bit           hit;
		case (k)
			ss_pkg::OP_CLEAR: begin
				pat_len = 0;
				pat_ovf = 1'b0;
				restart_text();
			end
			ss_pkg::OP_APPEND: begin
				if (pat_len < ss_pkg::MAX_PATTERN) begin
					pat_bytes[pat_len] = b;
					pat_len++;
				end else begin
					pat_ovf = 1'b1;
				end
			end
			ss_pkg::OP_TEXT: begin
				for (int i = ss_pkg::MAX_PATTERN - 1; i > 0; i--) txt_win[i] = txt_win[i-1];
				txt_win[0] = b;
				if (txt_count != '1) txt_count++;
				if (!hit_seen && pat_len != 0 && txt_count >= 32'(pat_len)) begin
					hit = 1'b1;
					for (int i = 0; i < pat_len; i++) begin
						if (to_lower_ci(pat_bytes[i]) !=
							to_lower_ci(txt_win[pat_len-1-i])) hit = 1'b0;
					end
					if (hit) begin
						hit_seen  = 1'b1;
						hit_start = txt_count - 32'(pat_len);
					end
				end
			end
			ss_pkg::OP_END: begin
				r.found = (pat_len == 0) || hit_seen;
				r.pos   = (pat_len != 0 && hit_seen) ? hit_start : '0;
				r.ovf   = pat_ovf;
				expected_results.push_back(r);
				restart_text();
			end
		endcase
	endtask

	task automatic report_error(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic send_beat(input ss_pkg::op_t k, input logic [7:0] b);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		kind       <= k;
		byte_value <= b;
		do @(posedge clk); while (full);
		predict_search(k, b);
		beats_sent++;
	endtask

	// stop offering beats and let the block drain, including trailing no-result beats
	task automatic settle();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_case_mode(input bit v);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case_mode = v;
		cfg_writes++;
	endtask

	task automatic check_result();
		ss_pkg::res_t want;
		results_checked++;
		if (expected_results.size() == 0) begin
			report_error($sformatf("result with nothing expected (found %0d pos %0d)",
				found, match_position));
		end else begin
			want = expected_results.pop_front();
			if (found !== want.found)
				report_error($sformatf("found: got %0d expected %0d", found, want.found));
			if (match_position !== want.pos)
				report_error($sformatf("match_position: got %0d expected %0d",
					match_position, want.pos));
			if (pattern_overflow !== want.ovf)
				report_error($sformatf("pattern_overflow: got %0d expected %0d",
					pattern_overflow, want.ovf));
		end
	endtask

	// result side
	initial begin
		int gap;
		int held;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req > 0) begin
				pop  <= 1'b0;
				held = 0;
				while (held < rx_hold_req) begin
					@(posedge clk);
					held++;
				end
				rx_hold_req = 0;
			end else begin
				gap = rx_idle_on ? $urandom_range(0, 15) : 0;
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			check_result();
		end
	end

	always @(posedge clk) begin
		if (arst_n && push && full) full_stall_cycles++;
		if (arst_n && ((push && !full) || (pop && !empty))) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", quiet_cycles);
			$display("[substring_search_top] ERROR");
			$finish;
		end
	end

	task automatic test_empty_pattern_after_reset();
		send_beat(ss_pkg::OP_END, 8'h00);
	endtask

	// later matches must not move the recorded start
	task automatic test_case_sensitive_match();
		send_beat(ss_pkg::OP_CLEAR, 8'hFF);
		send_beat(ss_pkg::OP_APPEND, "a");
		send_beat(ss_pkg::OP_APPEND, "B");
		send_beat(ss_pkg::OP_TEXT, "x");
		send_beat(ss_pkg::OP_TEXT, "a");
		send_beat(ss_pkg::OP_TEXT, "b");
		send_beat(ss_pkg::OP_TEXT, "a");
		send_beat(ss_pkg::OP_TEXT, "B");
		send_beat(ss_pkg::OP_TEXT, "a");
		send_beat(ss_pkg::OP_TEXT, "B");
		send_beat(ss_pkg::OP_END, 8'h00);
	endtask

	task automatic test_case_folding();
		write_case_mode(1'b1);
		send_beat(ss_pkg::OP_TEXT, "@");
		send_beat(ss_pkg::OP_TEXT, "A");
		send_beat(ss_pkg::OP_TEXT, "b");
		send_beat(ss_pkg::OP_TEXT, "[");
		send_beat(ss_pkg::OP_END, 8'h00);
	endtask

	task automatic test_pattern_change_mid_text();
		write_case_mode(1'b0);
		send_beat(ss_pkg::OP_CLEAR, 8'h00);
		send_beat(ss_pkg::OP_APPEND, "m");
		send_beat(ss_pkg::OP_TEXT, "x");
		send_beat(ss_pkg::OP_APPEND, "n");
		send_beat(ss_pkg::OP_TEXT, "m");
		send_beat(ss_pkg::OP_TEXT, "n");
		send_beat(ss_pkg::OP_END, 8'h00);
	endtask

	// includes zero and all-ones bytes in the kept pattern
	task automatic test_pattern_overflow();
		send_beat(ss_pkg::OP_CLEAR, 8'h00);
		for (int i = 0; i <= ss_pkg::MAX_PATTERN; i++) send_beat(ss_pkg::OP_APPEND, 8'(i * 17));
		send_beat(ss_pkg::OP_END, 8'h00);
	endtask

	task automatic test_result_backlog();
		tx_idle_on  = 1'b0;
		rx_idle_on  = 1'b0;
		rx_hold_req = HOLD_CYCLES;
		send_beat(ss_pkg::OP_CLEAR, 8'h00);
		repeat (12) send_beat(ss_pkg::OP_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_random_search();
		int         stop_at;
		int         n;
		int         plen;
		int         tlen;
		int         at;
		logic [7:0] txt[$];
		stop_at = beats_sent + RANDOM_BEATS;
		while (beats_sent < stop_at) begin
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 9) == 0) write_case_mode(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 8);
				repeat (n) send_beat(ss_pkg::op_t'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)));
			end else begin
				if (pat_len == 0 || $urandom_range(0, 3) != 0) begin
					send_beat(ss_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
					case ($urandom_range(0, 9))
						0: plen = 0;
						1: plen = $urandom_range(12, ss_pkg::MAX_PATTERN + 3);
						default: plen = $urandom_range(1, 5);
					endcase
					repeat (plen) send_beat(ss_pkg::OP_APPEND, pick_char());
				end
				tlen = $urandom_range(0, 8 + 2 * pat_len);
				txt.delete();
				repeat (tlen) txt.push_back(pick_char());
				if (pat_len > 0 && $urandom_range(0, 2) != 0) begin
					at = $urandom_range(0, tlen);
					for (int i = pat_len - 1; i >= 0; i--) txt.insert(at, case_flip(pat_bytes[i]));
				end
				foreach (txt[j]) send_beat(ss_pkg::OP_TEXT, txt[j]);
				send_beat(ss_pkg::OP_END, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		restart_text();
		foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pattern_after_reset();
		test_case_sensitive_match();
		test_case_folding();
		test_pattern_change_mid_text();
		test_pattern_overflow();
		test_result_backlog();
		test_random_search();
		settle();
		$display("run covered %0d beats and %0d search results over %0d case-mode writes;",
			beats_sent, results_checked, cfg_writes);
		$display("input was held off for %0d cycles while results backed up", full_stall_cycles);
		if (errors == 0) begin
			$display("[substring_search_top] OK");
		end else begin
			$display("[substring_search_top] ERROR");
		end
		$finish;
	end

endmodule
